>>> design/largest_ones_square_stream_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the largest ones square stream core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LARGEST_ONES_SQUARE_STREAM_CORE_MACROS_SVH
`define LARGEST_ONES_SQUARE_STREAM_CORE_MACROS_SVH

`ifndef SYNTHESIS

// combinational property checked at every rising clock edge out of reset
`define LSQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("lsq check failed");

// condition in one cycle implies a consequence in the next
`define LSQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lsq sequence check failed");

`else

`define LSQ_ASSERT(lbl, clk, rstn, prop)
`define LSQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> design/lsq_pkg.sv
// ----------------------------------------------------------------------------
// lsq_pkg
// Shared widths and limits of the largest ones square stream core.
// ----------------------------------------------------------------------------
package lsq_pkg;

    localparam int MAX_ROW_WIDTH = 1024;
    localparam int CFG_W         = 11;
    localparam int SIDE_W        = 11;
    localparam int AREA_W        = 21;

    localparam logic [SIDE_W-1:0] SIDE_MAX = {SIDE_W{1'b1}};
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
    localparam logic [CFG_W-1:0]  ROW_WIDTH_RESET = CFG_W'(1024);

endpackage

>>> design/lsq_ram.sv
// ----------------------------------------------------------------------------
// lsq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lsq_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/largest_ones_square_stream_core.sv
// ----------------------------------------------------------------------------
// largest_ones_square_stream_core
// Finds the largest all-ones square in a binary image streamed in raster
// order, one pixel per request, and reports its side and area per frame.
//
// Usage:
//   Input channel s_*: one pixel per request, s_last_pixel marks the final
//   pixel of a frame. Result channel m_*: one request per frame carrying
//   m_largest_side and m_largest_area. cfg_wr_en/cfg_wr_data set the row
//   width (0 acts as 1, values above MAX_ROW_WIDTH act as MAX_ROW_WIDTH);
//   write it only while the core is idle.
//   Throughput: one pixel per cycle while s_ready is high. The line store
//   is a RAM with one write and one registered read per cycle; a same-entry
//   read and write in one cycle (row width 1) is forwarded.
//   Result path: the last pixel of a frame passes the stage 1 registers,
//   queue entry p (and q when p is busy) and the output register, and the
//   row count restarts on the next pixel.
//   Reset: aresetn low clears the row position and running maximum, sets the
//   row width to 1024; the line store is not cleared, the first-row flag
//   masks it.
//   Stall: up to three results wait in the output queue; s_ready drops once
//   three are held or in flight and none leaves in the same cycle.
// ----------------------------------------------------------------------------
`include "largest_ones_square_stream_core_macros.svh"

module largest_ones_square_stream_core #(
    parameter int MAX_ROW_WIDTH = lsq_pkg::MAX_ROW_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [lsq_pkg::CFG_W-1:0]   cfg_wr_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_pixel,
    input  logic                        s_last_pixel,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lsq_pkg::SIDE_W-1:0]  m_largest_side,
    output logic [lsq_pkg::AREA_W-1:0]  m_largest_area
);

    localparam int CNT_W  = $clog2(MAX_ROW_WIDTH);
    localparam int EW     = CNT_W + 1;
    localparam int SIDE_W = lsq_pkg::SIDE_W;
    localparam int AREA_W = lsq_pkg::AREA_W;

    // configuration
    logic [lsq_pkg::CFG_W-1:0] row_width_reg;
    logic [31:0]               row_width_wide;
    logic [EW-1:0]             eff_width;

    // stage 0: position tracking
    logic [CNT_W-1:0] col_cnt_reg, col_cnt_next;
    logic             first_row_reg, first_row_next;
    logic             wrap0;
    logic [CNT_W-1:0] col0;
    logic             first0;
    logic [EW-1:0]    col_inc0;
    logic             accept;

    // stage 1: size computation
    logic              s1_valid_reg;
    logic [CNT_W-1:0]  s1_col_reg;
    logic              s1_first_reg;
    logic              s1_pix_reg;
    logic              s1_last_reg;
    logic              fwd_reg, fwd_next;
    logic [SIDE_W-1:0] fwd_val_reg;
    logic [SIDE_W-1:0] left_reg, diag_reg, best_reg, best_next;
    logic [SIDE_W-1:0] rd_data;
    logic [SIDE_W-1:0] up1, left1, diag1, min_ul, min3, val1, bigger1;
    logic              s1_emit;

    // result queue
    logic              p_valid_reg, p_valid_next;
    logic [SIDE_W-1:0] p_side_reg;
    logic              q_valid_reg, q_valid_next;
    logic [SIDE_W-1:0] q_side_reg;
    logic              p_free;
    logic              m_valid_reg, m_valid_next;
    logic [SIDE_W-1:0] m_side_reg;
    logic [AREA_W-1:0] m_area_reg;
    logic [2*SIDE_W-1:0] area_full;
    logic [AREA_W-1:0] area_sat;
    logic              m_load;
    logic [2:0]        inflight;

    // effective row width
    always_comb begin
        row_width_wide = 32'(row_width_reg);
        if (row_width_reg == '0) begin
            eff_width = EW'(1);
        end else if (row_width_wide > 32'(MAX_ROW_WIDTH)) begin
            eff_width = EW'(MAX_ROW_WIDTH);
        end else begin
            eff_width = EW'(row_width_wide);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= lsq_pkg::ROW_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            row_width_reg <= cfg_wr_data;
        end
    end

    // flow control: room for every result in flight
    assign inflight = 3'(s1_valid_reg & s1_last_reg) + 3'(p_valid_reg) +
                      3'(q_valid_reg) + 3'(m_valid_reg);
    assign s_ready  = (inflight <= 3'd2) ||
                      ((inflight == 3'd3) && m_valid_reg && m_ready);
    assign accept   = s_valid && s_ready;

    // stage 0
    always_comb begin
        wrap0    = {1'b0, col_cnt_reg} >= eff_width;
        col0     = wrap0 ? '0 : col_cnt_reg;
        first0   = wrap0 ? 1'b0 : first_row_reg;
        col_inc0 = {1'b0, col0} + EW'(1);

        col_cnt_next   = col_cnt_reg;
        first_row_next = first_row_reg;
        if (accept) begin
            if (s_last_pixel) begin
                col_cnt_next   = '0;
                first_row_next = 1'b1;
            end else if (col_inc0 >= eff_width) begin
                col_cnt_next   = '0;
                first_row_next = 1'b0;
            end else begin
                col_cnt_next   = col_inc0[CNT_W-1:0];
                first_row_next = first0;
            end
        end
    end

    lsq_ram #(
        .WIDTH(SIDE_W),
        .DEPTH(MAX_ROW_WIDTH)
    ) u_line_ram (
        .aclk (aclk),
        .we   (s1_valid_reg),
        .waddr(s1_col_reg),
        .wdata(val1),
        .re   (accept),
        .raddr(col0),
        .rdata(rd_data)
    );

    // stage 1
    always_comb begin
        up1    = s1_first_reg ? '0 : (fwd_reg ? fwd_val_reg : rd_data);
        left1  = (s1_col_reg == '0) ? '0 : left_reg;
        diag1  = (s1_first_reg || s1_col_reg == '0) ? '0 : diag_reg;
        min_ul = (up1 < left1) ? up1 : left1;
        min3   = (min_ul < diag1) ? min_ul : diag1;
        if (!s1_pix_reg) begin
            val1 = '0;
        end else if (min3 == lsq_pkg::SIDE_MAX) begin
            val1 = lsq_pkg::SIDE_MAX;
        end else begin
            val1 = min3 + SIDE_W'(1);
        end
        bigger1 = (val1 > best_reg) ? val1 : best_reg;
        s1_emit = s1_valid_reg && s1_last_reg;

        best_next = best_reg;
        if (s1_valid_reg) begin
            best_next = s1_last_reg ? '0 : bigger1;
        end
        fwd_next = accept && s1_valid_reg && (s1_col_reg == col0);
    end

    // result queue
    always_comb begin
        m_load       = p_valid_reg && (!m_valid_reg || m_ready);
        p_free       = !p_valid_reg || m_load;
        p_valid_next = p_valid_reg;
        q_valid_next = q_valid_reg;
        if (p_free) begin
            p_valid_next = q_valid_reg || s1_emit;
            q_valid_next = q_valid_reg && s1_emit;
        end else if (s1_emit) begin
            q_valid_next = 1'b1;
        end
        m_valid_next = m_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        area_full    = p_side_reg * p_side_reg;
        area_sat     = (area_full > (2*SIDE_W)'(lsq_pkg::AREA_MAX)) ?
                       lsq_pkg::AREA_MAX : area_full[AREA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg   <= '0;
            first_row_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            left_reg      <= '0;
            diag_reg      <= '0;
            best_reg      <= '0;
            p_valid_reg   <= 1'b0;
            q_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            col_cnt_reg   <= col_cnt_next;
            first_row_reg <= first_row_next;
            s1_valid_reg  <= accept;
            fwd_reg       <= fwd_next;
            best_reg      <= best_next;
            p_valid_reg   <= p_valid_next;
            q_valid_reg   <= q_valid_next;
            m_valid_reg   <= m_valid_next;
            if (s1_valid_reg) begin
                left_reg <= val1;
                diag_reg <= up1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg   <= col0;
            s1_first_reg <= first0;
            s1_pix_reg   <= s_pixel;
            s1_last_reg  <= s_last_pixel;
        end
        fwd_val_reg <= val1;
        if (p_free) begin
            if (q_valid_reg) begin
                p_side_reg <= q_side_reg;
            end else if (s1_emit) begin
                p_side_reg <= bigger1;
            end
        end
        if (s1_emit && (q_valid_reg || !p_free)) begin
            q_side_reg <= bigger1;
        end
        if (m_load) begin
            m_side_reg <= p_side_reg;
            m_area_reg <= area_sat;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_largest_side = m_side_reg;
    assign m_largest_area = m_area_reg;

    `LSQ_ASSERT(a_inflight_bound, aclk, aresetn, inflight <= 3'd3)
    `LSQ_ASSERT(a_queue_order, aclk, aresetn, !q_valid_reg || p_valid_reg)
    `LSQ_ASSERT(a_fwd_live, aclk, aresetn, !fwd_reg || s1_valid_reg)
    `LSQ_ASSERT_NEXT(a_frame_restart, aclk, aresetn, accept && s_last_pixel,
        col_cnt_reg == '0 && first_row_reg)
    `LSQ_ASSERT_NEXT(a_queue_advance, aclk, aresetn,
        p_valid_reg && (!m_valid_reg || m_ready), m_valid_reg)

endmodule
